// ===== design/banked_memory_mapper_128k_defines.svh =====
// Assertion macros for the banked memory mapper.
// Included by the modules that carry assertions; expects clk and rst_n in scope.
`ifndef BANKED_MEMORY_MAPPER_128K_DEFINES_SVH
`define BANKED_MEMORY_MAPPER_128K_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BMM_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define BMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BMM_ASSERT_ALWAYS(lbl, expr, msg)
`define BMM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/bmm_pkg.sv =====
// Shared types and constants for the banked memory mapper.
// No dependencies; imported by every module of the block but bmm_ram.
package bmm_pkg;

    localparam int OFF_MAX_W = 14;

    localparam logic [15:0] PORT_PAGING = 16'h7FFD;
    localparam logic [15:0] PORT_AY     = 16'hFFFD;
    localparam logic [13:0] ROM_LOAD_MASK = 14'h3FFF;

    localparam int LOCK_BIT   = 5;
    localparam int ROM_BIT    = 4;
    localparam int EAR_BIT    = 4;
    localparam int SCREEN_BIT = 3;
    localparam int MIC_BIT    = 3;

    localparam logic [2:0] BANK_SLOT1    = 3'd5;
    localparam logic [2:0] BANK_SLOT2    = 3'd2;
    localparam logic [2:0] SCREEN_NORMAL = 3'd5;
    localparam logic [2:0] SCREEN_SHADOW = 3'd7;

    typedef enum logic [1:0] {
        OP_MEM_RD = 2'd0,
        OP_MEM_WR = 2'd1,
        OP_IO_WR  = 2'd2,
        OP_ROM_LD = 2'd3
    } bmm_op_t;

    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_RAM  = 2'd1,
        SRC_ROM  = 2'd2
    } bmm_src_t;

    typedef struct packed {
        bmm_op_t              op;
        logic                 in_map;
        logic [1:0]           slot;
        logic [OFF_MAX_W-1:0] offset;
        logic                 port_even;
        logic                 port_paging;
        logic                 port_ay;
        logic [7:0]           data;
        logic                 rom_bank;
    } bmm_item_t;

    typedef struct packed {
        logic       rom_page;
        logic [2:0] ram_page;
        logic [2:0] display_page;
        logic       paging_locked;
        logic [2:0] border_colour;
        logic       ear_bit;
        logic       mic_bit;
        logic [7:0] last_paging_byte;
    } bmm_status_t;

endpackage

// ===== design/banked_memory_mapper_128k.sv =====
// Top level of the banked memory mapper: front classifier, item queue, back end.
// Depends on bmm_pkg, bmm_front, bmm_fifo and bmm_back.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------------
//   in      | in_valid / in_ready  | opcode, address, data, rom_bank
//   out     | out_valid / out_ready| read_data, contended, page/latch status fields
//   cfg     | cfg_we               | cfg_wdata (has_paging)
//
// One item per cycle sustained while out_ready stays high; an item taken is written to the
// queue, then the bank RAM or ROM read is registered together with the result.
// Reset clears the paging and port latches; RAM and ROM contents are left as they are.
// in_ready drops when the two-entry queue is full; the back end holds while a result waits.
module banked_memory_mapper_128k
    import bmm_pkg::*;
#(
    parameter int PAGE_BYTES = 16384,
    parameter int RAM_BANKS  = 8,
    parameter int ROM_BANKS  = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    input  logic        rom_bank,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic        contended,
    output logic        rom_page,
    output logic [2:0]  ram_page,
    output logic [2:0]  display_page,
    output logic        paging_locked,
    output logic [2:0]  border_colour,
    output logic        ear_bit,
    output logic        mic_bit,
    output logic [7:0]  last_paging_byte
);

    logic        push;
    bmm_item_t   push_item;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;
    bmm_item_t   q_head;
    bmm_status_t status;

    bmm_front #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .address   (address),
        .data      (data),
        .rom_bank  (rom_bank),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    bmm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    bmm_back #(
        .PAGE_BYTES (PAGE_BYTES),
        .RAM_BANKS  (RAM_BANKS),
        .ROM_BANKS  (ROM_BANKS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data),
        .contended (contended),
        .status    (status)
    );

    assign rom_page         = status.rom_page;
    assign ram_page         = status.ram_page;
    assign display_page     = status.display_page;
    assign paging_locked    = status.paging_locked;
    assign border_colour    = status.border_colour;
    assign ear_bit          = status.ear_bit;
    assign mic_bit          = status.mic_bit;
    assign last_paging_byte = status.last_paging_byte;

endmodule

// ===== design/bmm_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module bmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== design/bmm_fifo.sv =====
// Two-entry queue of classified items between front and back.
// Depends on bmm_pkg.
module bmm_fifo
    import bmm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  bmm_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      valid,
    output bmm_item_t head
);

    bmm_item_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/bmm_front.sv =====
// Front end: accepts bus items and classifies slot, offset and port.
// Depends on bmm_pkg.
module bmm_front
    import bmm_pkg::*;
#(
    parameter int PAGE_BYTES = 16384
) (
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    input  logic        rom_bank,
    input  logic        q_full,
    output logic        push,
    output bmm_item_t   push_item
);

    logic [17:0] addr_ext;
    logic [17:0] slot_base;
    logic [1:0]  slot;
    logic        in_map;
    logic [17:0] load_ext;
    logic [17:0] load_base;
    logic [17:0] cpu_off;
    logic [17:0] load_off;
    bmm_op_t     op;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;
    assign op       = bmm_op_t'(opcode);
    assign addr_ext = 18'(address);
    assign load_ext = 18'(address[13:0] & ROM_LOAD_MASK);

    always_comb
    begin
        in_map    = 1'b0;
        slot      = 2'd0;
        slot_base = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (addr_ext >= 18'(k * PAGE_BYTES) && addr_ext < 18'((k + 1) * PAGE_BYTES))
            begin
                in_map    = 1'b1;
                slot      = 2'(k);
                slot_base = 18'(k * PAGE_BYTES);
            end
        end
    end

    always_comb
    begin
        load_base = '0;
        for (int k = 1; k < 16; k++)
        begin
            if (load_ext >= 18'(k * PAGE_BYTES))
            begin
                load_base = 18'(k * PAGE_BYTES);
            end
        end
    end

    assign cpu_off  = addr_ext - slot_base;
    assign load_off = load_ext - load_base;

    always_comb
    begin
        push_item.op          = op;
        push_item.in_map      = in_map;
        push_item.slot        = slot;
        push_item.offset      = (op == OP_ROM_LD) ? load_off[OFF_MAX_W-1:0]
                                                  : cpu_off[OFF_MAX_W-1:0];
        push_item.port_even   = !address[0];
        push_item.port_paging = (address == PORT_PAGING);
        push_item.port_ay     = (address == PORT_AY);
        push_item.data        = data;
        push_item.rom_bank    = rom_bank;
    end

endmodule

// ===== design/bmm_back.sv =====
// Back end: bank resolution, RAM/ROM access, latches, result register.
// Depends on bmm_pkg, bmm_ram and the assertion macro header.
`include "banked_memory_mapper_128k_defines.svh"

module bmm_back
    import bmm_pkg::*;
#(
    parameter int PAGE_BYTES = 16384,
    parameter int RAM_BANKS  = 8,
    parameter int ROM_BANKS  = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        q_valid,
    input  bmm_item_t   q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic        contended,
    output bmm_status_t status
);

    localparam int OFW = $clog2(PAGE_BYTES);
    localparam int RAW = $clog2(RAM_BANKS * PAGE_BYTES);
    localparam int ROW = $clog2(ROM_BANKS * PAGE_BYTES);

    logic       has_paging_reg;
    logic       out_valid_reg, out_valid_next;
    bmm_src_t   rd_src_reg, rd_src_next;
    logic       cont_reg, cont_next;
    logic       rom_sel_reg, rom_sel_next;
    logic [2:0] ram_sel_reg, ram_sel_next;
    logic       screen_reg, screen_next;
    logic       lock_reg, lock_next;
    logic [2:0] border_reg, border_next;
    logic       ear_reg, ear_next;
    logic       mic_reg, mic_next;
    logic [7:0] port_byte_reg, port_byte_next;

    logic           issue;
    logic           cont_base;
    logic [2:0]     bank;
    logic           rom_bank_sel;
    logic           ram_slot;
    logic [RAW-1:0] ram_addr;
    logic [ROW-1:0] rom_addr;
    logic           ram_we, ram_re, rom_we, rom_re;
    logic [7:0]     ram_rdata, rom_rdata;

    assign issue = q_valid && (!out_valid_reg || out_ready);
    assign q_pop = issue;

    always_comb
    begin
        unique case (q_head.slot)
            2'd1:    bank = BANK_SLOT1;
            2'd2:    bank = BANK_SLOT2;
            2'd3:    bank = ram_sel_reg;
            default: bank = 3'd0;
        endcase
    end

    assign ram_slot     = q_head.in_map && (q_head.slot != 2'd0);
    assign rom_bank_sel = (q_head.op == OP_ROM_LD) ? q_head.rom_bank : rom_sel_reg;
    assign ram_addr     = RAW'(bank) * RAW'(PAGE_BYTES) + RAW'(q_head.offset[OFW-1:0]);
    assign rom_addr     = ROW'(rom_bank_sel) * ROW'(PAGE_BYTES)
                        + ROW'(q_head.offset[OFW-1:0]);

    assign ram_we = issue && (q_head.op == OP_MEM_WR) && ram_slot;
    assign ram_re = issue && (q_head.op == OP_MEM_RD) && ram_slot;
    assign rom_we = issue && (q_head.op == OP_ROM_LD);
    assign rom_re = issue && (q_head.op == OP_MEM_RD) && q_head.in_map
                  && (q_head.slot == 2'd0);

    assign cont_base = q_head.in_map
                     && ((q_head.slot == 2'd1) || ((q_head.slot == 2'd3) && ram_sel_reg[0]));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        rd_src_next    = rd_src_reg;
        cont_next      = cont_reg;
        rom_sel_next   = rom_sel_reg;
        ram_sel_next   = ram_sel_reg;
        screen_next    = screen_reg;
        lock_next      = lock_reg;
        border_next    = border_reg;
        ear_next       = ear_reg;
        mic_next       = mic_reg;
        port_byte_next = port_byte_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (issue)
        begin
            out_valid_next = 1'b1;
            rd_src_next    = SRC_ZERO;
            unique case (q_head.op)
                OP_MEM_RD:
                begin
                    cont_next = cont_base;
                    if (rom_re)
                    begin
                        rd_src_next = SRC_ROM;
                    end
                    else if (ram_re)
                    begin
                        rd_src_next = SRC_RAM;
                    end
                end
                OP_MEM_WR:
                begin
                    cont_next = cont_base;
                end
                OP_IO_WR:
                begin
                    cont_next = has_paging_reg && cont_base;
                    if (q_head.port_even)
                    begin
                        ear_next    = q_head.data[EAR_BIT];
                        mic_next    = q_head.data[MIC_BIT];
                        border_next = q_head.data[2:0];
                    end
                    if (q_head.port_ay)
                    begin
                        port_byte_next = q_head.data;
                    end
                    if (q_head.port_paging && !lock_reg)
                    begin
                        port_byte_next = q_head.data;
                        lock_next      = q_head.data[LOCK_BIT];
                        rom_sel_next   = q_head.data[ROM_BIT];
                        ram_sel_next   = q_head.data[2:0];
                        screen_next    = q_head.data[SCREEN_BIT];
                    end
                end
                OP_ROM_LD:
                begin
                    cont_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_paging_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
            rd_src_reg     <= SRC_ZERO;
            rom_sel_reg    <= 1'b0;
            ram_sel_reg    <= 3'd0;
            screen_reg     <= 1'b0;
            lock_reg       <= 1'b0;
            border_reg     <= 3'd0;
            ear_reg        <= 1'b0;
            mic_reg        <= 1'b0;
            port_byte_reg  <= 8'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                has_paging_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
            rd_src_reg    <= rd_src_next;
            rom_sel_reg   <= rom_sel_next;
            ram_sel_reg   <= ram_sel_next;
            screen_reg    <= screen_next;
            lock_reg      <= lock_next;
            border_reg    <= border_next;
            ear_reg       <= ear_next;
            mic_reg       <= mic_next;
            port_byte_reg <= port_byte_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cont_reg <= cont_next;
    end

    bmm_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BANKS * PAGE_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (q_head.data),
        .rdata (ram_rdata)
    );

    bmm_ram #(
        .WIDTH (8),
        .DEPTH (ROM_BANKS * PAGE_BYTES)
    ) u_rom (
        .clk   (clk),
        .we    (rom_we),
        .re    (rom_re),
        .addr  (rom_addr),
        .wdata (q_head.data),
        .rdata (rom_rdata)
    );

    always_comb
    begin
        unique case (rd_src_reg)
            SRC_RAM: read_data = ram_rdata;
            SRC_ROM: read_data = rom_rdata;
            default: read_data = 8'd0;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign contended = cont_reg;

    always_comb
    begin
        status.rom_page         = rom_sel_reg;
        status.ram_page         = ram_sel_reg;
        status.display_page     = screen_reg ? SCREEN_SHADOW : SCREEN_NORMAL;
        status.paging_locked    = lock_reg;
        status.border_colour    = border_reg;
        status.ear_bit          = ear_reg;
        status.mic_bit          = mic_reg;
        status.last_paging_byte = port_byte_reg;
    end

    `BMM_ASSERT_NEXT(a_issue_gives_result, issue, out_valid_reg, "issued item produced no result")
    `BMM_ASSERT_ALWAYS(a_no_issue_on_stall, !(out_valid_reg && !out_ready && q_pop), "issued while result stalled")
    `BMM_ASSERT_NEXT(a_lock_sticky, lock_reg, lock_reg, "paging lock cleared without reset")
    `BMM_ASSERT_NEXT(a_lock_freezes_pages, lock_reg, $stable(ram_sel_reg) && $stable(rom_sel_reg) && $stable(screen_reg), "paging changed while locked")

endmodule

// ===== tb/sv/bmm_access_checker.sv =====
// Checker for banked_memory_mapper_128k: mirrors the paging and port latches and the
// RAM/ROM contents, predicts one result per accepted item and compares in order.
// Depends on bmm_pkg; instantiated beside the mapper by tb.
module bmm_access_checker
    import bmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    input  logic        rom_bank,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  read_data,
    input  logic        contended,
    input  logic        rom_page,
    input  logic [2:0]  ram_page,
    input  logic [2:0]  display_page,
    input  logic        paging_locked,
    input  logic [2:0]  border_colour,
    input  logic        ear_bit,
    input  logic        mic_bit,
    input  logic [7:0]  last_paging_byte,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [7:0]  read_data;
        logic        contended;
        bmm_status_t status;
    } access_result_t;

    logic [7:0]     ram_image [0:131071];
    logic [7:0]     rom_image [0:32767];
    logic           rom_sel_m;
    logic [2:0]     ram_sel_m;
    logic           shadow_screen_m;
    logic           locked_m;
    logic [2:0]     border_m;
    logic           ear_m;
    logic           mic_m;
    logic [7:0]     port_byte_m;
    logic           has_paging_m;
    access_result_t awaited_results [$];
    int             printed;

    task automatic report_mismatch(string field, int got, int want);
        fail_count++;
        if (printed < 40)
        begin
            printed++;
            $display("%0t %s mismatch: got 0x%0h expected 0x%0h", $time, field, got, want);
        end
    endtask

    // Applies one bus access to the mirrored state; contention uses the bank
    // selected before the access takes effect.
    function automatic access_result_t apply_bus_access(bmm_op_t op, logic [15:0] addr,
                                                        logic [7:0] wd, logic rb);
        access_result_t r;
        logic [1:0]     slot;
        logic [13:0]    off;
        logic [2:0]     bank;
        logic           slot_cont;
        slot = addr[15:14];
        off  = addr[13:0];
        r    = '0;
        case (slot)
            2'd1:    bank = BANK_SLOT1;
            2'd2:    bank = BANK_SLOT2;
            default: bank = ram_sel_m;
        endcase
        slot_cont = (slot == 2'd1) || (slot == 2'd3 && ram_sel_m[0]);
        case (op)
            OP_MEM_RD:
            begin
                r.contended = slot_cont;
                r.read_data = (slot == 2'd0) ? rom_image[{rom_sel_m, off}]
                                             : ram_image[{bank, off}];
            end
            OP_MEM_WR:
            begin
                r.contended = slot_cont;
                if (slot != 2'd0)
                    ram_image[{bank, off}] = wd;
            end
            OP_IO_WR:
            begin
                r.contended = has_paging_m && slot_cont;
                if (!addr[0])
                begin
                    ear_m    = wd[EAR_BIT];
                    mic_m    = wd[MIC_BIT];
                    border_m = wd[2:0];
                end
                if (addr == PORT_AY)
                    port_byte_m = wd;
                if (addr == PORT_PAGING && !locked_m)
                begin
                    port_byte_m     = wd;
                    locked_m        = locked_m | wd[LOCK_BIT];
                    rom_sel_m       = wd[ROM_BIT];
                    ram_sel_m       = wd[2:0];
                    shadow_screen_m = wd[SCREEN_BIT];
                end
            end
            OP_ROM_LD:
            begin
                rom_image[{rb, addr[13:0] & ROM_LOAD_MASK}] = wd;
            end
            default:
            begin
            end
        endcase
        r.status.rom_page         = rom_sel_m;
        r.status.ram_page         = ram_sel_m;
        r.status.display_page     = shadow_screen_m ? SCREEN_SHADOW : SCREEN_NORMAL;
        r.status.paging_locked    = locked_m;
        r.status.border_colour    = border_m;
        r.status.ear_bit          = ear_m;
        r.status.mic_bit          = mic_m;
        r.status.last_paging_byte = port_byte_m;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        access_result_t want;
        if (!rst_n)
        begin
            rom_sel_m       = 1'b0;
            ram_sel_m       = 3'd0;
            shadow_screen_m = 1'b0;
            locked_m        = 1'b0;
            border_m        = 3'd0;
            ear_m           = 1'b0;
            mic_m           = 1'b0;
            port_byte_m     = 8'd0;
            has_paging_m    = 1'b1;
            awaited_results.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                has_paging_m = cfg_wdata;
            if (in_valid && in_ready)
                awaited_results.push_back(
                    apply_bus_access(bmm_op_t'(opcode), address, data, rom_bank));
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result with nothing awaited:", int'(read_data), 0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (read_data !== want.read_data)
                        report_mismatch("read_data", int'(read_data),
                                        int'(want.read_data));
                    if (contended !== want.contended)
                        report_mismatch("contended", int'(contended),
                                        int'(want.contended));
                    if (rom_page !== want.status.rom_page)
                        report_mismatch("rom_page", int'(rom_page),
                                        int'(want.status.rom_page));
                    if (ram_page !== want.status.ram_page)
                        report_mismatch("ram_page", int'(ram_page),
                                        int'(want.status.ram_page));
                    if (display_page !== want.status.display_page)
                        report_mismatch("display_page", int'(display_page),
                                        int'(want.status.display_page));
                    if (paging_locked !== want.status.paging_locked)
                        report_mismatch("paging_locked", int'(paging_locked),
                                        int'(want.status.paging_locked));
                    if (border_colour !== want.status.border_colour)
                        report_mismatch("border_colour", int'(border_colour),
                                        int'(want.status.border_colour));
                    if (ear_bit !== want.status.ear_bit)
                        report_mismatch("ear_bit", int'(ear_bit),
                                        int'(want.status.ear_bit));
                    if (mic_bit !== want.status.mic_bit)
                        report_mismatch("mic_bit", int'(mic_bit),
                                        int'(want.status.mic_bit));
                    if (last_paging_byte !== want.status.last_paging_byte)
                        report_mismatch("last_paging_byte", int'(last_paging_byte),
                                        int'(want.status.last_paging_byte));
                end
            end
            pending = awaited_results.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for banked_memory_mapper_128k: clock, reset, bursty bus accesses,
// a stalling result receiver, has_paging phases and the verdict.
// Depends on bmm_pkg, the mapper RTL and bmm_access_checker.
module tb;
    import bmm_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [15:0] address;
    logic [7:0]  data;
    logic        rom_bank;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  read_data;
    logic        contended;
    logic        rom_page;
    logic [2:0]  ram_page;
    logic [2:0]  display_page;
    logic        paging_locked;
    logic [2:0]  border_colour;
    logic        ear_bit;
    logic        mic_bit;
    logic [7:0]  last_paging_byte;
    int          fail_count;
    int          pending;

    // stimulus-side view of the mapping, so that reads only hit written bytes
    bit          ram_written [0:131071];
    bit          rom_written [0:32767];
    logic        map_rom_sel;
    logic [2:0]  map_ram_sel;
    logic        map_locked;
    logic [13:0] hot_offsets [0:23];
    int          burst_left;
    bit          hold_req;

    banked_memory_mapper_128k uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .address          (address),
        .data             (data),
        .rom_bank         (rom_bank),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .read_data        (read_data),
        .contended        (contended),
        .rom_page         (rom_page),
        .ram_page         (ram_page),
        .display_page     (display_page),
        .paging_locked    (paging_locked),
        .border_colour    (border_colour),
        .ear_bit          (ear_bit),
        .mic_bit          (mic_bit),
        .last_paging_byte (last_paging_byte)
    );

    bmm_access_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .address          (address),
        .data             (data),
        .rom_bank         (rom_bank),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .read_data        (read_data),
        .contended        (contended),
        .rom_page         (rom_page),
        .ram_page         (ram_page),
        .display_page     (display_page),
        .paging_locked    (paging_locked),
        .border_colour    (border_colour),
        .ear_bit          (ear_bit),
        .mic_bit          (mic_bit),
        .last_paging_byte (last_paging_byte),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // receiver: rotating stall pattern, plus one long hold on request
    initial
    begin : receiver
        int cyc;
        bit rdy;
        out_ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_req = 1'b0;
            end
            case ((cyc / 97) % 4)
                0:       rdy = 1'b1;
                1:       rdy = ($urandom_range(0, 1) == 1);
                2:       rdy = (cyc % 5 == 0);
                default: rdy = ($urandom_range(0, 9) != 0);
            endcase
            out_ready <= rdy;
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic issue_access(bmm_op_t op, logic [15:0] addr, logic [7:0] wd, logic rb);
        logic [13:0] off;
        logic [2:0]  bank;
        bit          known;
        int          gap;
        off = addr[13:0];
        case (addr[15:14])
            2'd1:    bank = BANK_SLOT1;
            2'd2:    bank = BANK_SLOT2;
            default: bank = map_ram_sel;
        endcase
        known = (addr[15:14] == 2'd0) ? rom_written[{map_rom_sel, off}]
                                      : ram_written[{bank, off}];
        if (op == OP_MEM_RD && !known)
            op = OP_MEM_WR;
        case (op)
            OP_MEM_WR:
            begin
                if (addr[15:14] != 2'd0)
                    ram_written[{bank, off}] = 1'b1;
            end
            OP_IO_WR:
            begin
                if (addr == PORT_PAGING && !map_locked)
                begin
                    map_locked  = wd[LOCK_BIT];
                    map_rom_sel = wd[ROM_BIT];
                    map_ram_sel = wd[2:0];
                end
            end
            OP_ROM_LD:
            begin
                rom_written[{rb, off}] = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        opcode   <= op;
        address  <= addr;
        data     <= wd;
        rom_bank <= rb;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic issue_random(bit may_lock);
        int          pick;
        int          sel;
        logic [15:0] addr;
        logic [7:0]  wd;
        logic        rb;
        pick = $urandom_range(0, 99);
        wd   = 8'($urandom_range(0, 255));
        rb   = 1'($urandom_range(0, 1));
        addr = 16'($urandom_range(0, 65535));
        if (pick < 80 && $urandom_range(0, 9) < 7)
            addr[13:0] = hot_offsets[5'($urandom_range(0, 23))];
        if (pick < 35)
            issue_access(OP_MEM_RD, addr, wd, rb);
        else if (pick < 60)
            issue_access(OP_MEM_WR, addr, wd, rb);
        else if (pick < 80)
            issue_access(OP_ROM_LD, addr, wd, rb);
        else
        begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
            begin
                addr = PORT_PAGING;
                if (!may_lock)
                    wd[LOCK_BIT] = 1'b0;
            end
            else if (sel < 45)
                addr = PORT_AY;
            else if (sel < 80)
                addr[0] = 1'b0;
            else
                addr[0] = 1'b1;
            issue_access(OP_IO_WR, addr, wd, rb);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_has_paging(logic value);
        drain_results();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        int ph;
        int n;
        int i;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 1'b0;
        in_valid  <= 1'b0;
        opcode    <= OP_MEM_RD;
        address   <= 16'd0;
        data      <= 8'd0;
        rom_bank  <= 1'b0;
        map_rom_sel = 1'b0;
        map_ram_sel = 3'd0;
        map_locked  = 1'b0;
        hot_offsets[0] = 14'd0;
        hot_offsets[1] = 14'h3FFF;
        for (i = 2; i < 24; i++)
            hot_offsets[5'(i)] = 14'($urandom_range(0, 16383));
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ROM loads at both ends of both banks; high address bits are ignored
        issue_access(OP_ROM_LD, 16'h0000, 8'h00, 1'b0);
        issue_access(OP_ROM_LD, 16'hFFFF, 8'hFF, 1'b0);
        issue_access(OP_ROM_LD, 16'hC000, 8'h5A, 1'b1);
        issue_access(OP_ROM_LD, 16'h3FFF, 8'hA5, 1'b1);
        issue_access(OP_MEM_RD, 16'h0000, 8'h00, 1'b0);
        issue_access(OP_MEM_RD, 16'h3FFF, 8'h00, 1'b0);
        // slot 0 ignores writes
        issue_access(OP_MEM_WR, 16'h0000, 8'h77, 1'b0);
        issue_access(OP_MEM_RD, 16'h0000, 8'h00, 1'b0);
        issue_access(OP_MEM_WR, 16'h4000, 8'hFF, 1'b0);
        issue_access(OP_MEM_WR, 16'h7FFF, 8'h01, 1'b0);
        issue_access(OP_MEM_WR, 16'h8000, 8'h80, 1'b0);
        issue_access(OP_MEM_WR, 16'hFFFF, 8'hC3, 1'b0);
        issue_access(OP_MEM_RD, 16'h4000, 8'h00, 1'b0);
        issue_access(OP_MEM_RD, 16'h8000, 8'h00, 1'b0);
        issue_access(OP_MEM_RD, 16'hFFFF, 8'h00, 1'b0);
        issue_access(OP_IO_WR, 16'h00FE, 8'hFF, 1'b0);
        issue_access(OP_IO_WR, 16'h4001, 8'h00, 1'b0);
        issue_access(OP_IO_WR, PORT_AY, 8'hA5, 1'b0);
        // ROM 1, bank 7, shadow screen; odd bank in slot 3 is contended
        issue_access(OP_IO_WR, PORT_PAGING, 8'h1F, 1'b0);
        issue_access(OP_MEM_WR, 16'hC000, 8'h3C, 1'b1);
        issue_access(OP_MEM_RD, 16'hC000, 8'h00, 1'b0);
        issue_access(OP_MEM_RD, 16'h0000, 8'h00, 1'b0);
        issue_access(OP_IO_WR, 16'h0000, 8'h00, 1'b0);
        issue_access(OP_IO_WR, PORT_PAGING, 8'h00, 1'b0);
        issue_access(OP_MEM_RD, 16'hFFFF, 8'h00, 1'b0);

        for (ph = 0; ph < 5; ph++)
        begin
            write_has_paging(ph[0]);
            for (n = 0; n < 240; n++)
            begin
                if (ph == 1 && n == 100)
                    hold_req = 1'b1;
                if (ph == 2 && n == 120)
                    drain_results();
                issue_random(1'b0);
            end
        end

        // lock paging; later paging writes must leave everything as it is
        write_has_paging(1'b1);
        issue_access(OP_IO_WR, PORT_PAGING, 8'h3D, 1'b0);
        issue_access(OP_IO_WR, PORT_PAGING, 8'h10, 1'b1);
        for (n = 0; n < 170; n++)
            issue_random(1'b1);
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/bmm_pkg.sv
design/bmm_ram.sv
design/bmm_fifo.sv
design/bmm_front.sv
design/bmm_back.sv
design/banked_memory_mapper_128k.sv
tb/sv/bmm_access_checker.sv
tb/sv/tb.sv
